// File: rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RC4 stream cipher block.
// Has no dependencies; used by rtl/rc4_stream_cipher.sv.
package rc4_pkg;

  // Permutation table geometry.
  localparam int unsigned TableAw = 8;
  localparam int unsigned ByteW   = 8;

  // Key storage: two 64-bit registers hold up to sixteen key bytes.
  localparam int unsigned KeyRegW     = 64;
  localparam int unsigned KeyMaxBytes = 16;
  localparam int unsigned KeyIdxW     = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StFill,
    StKsRdN,
    StKsRdJ,
    StKsWrJ,
    StKsWrN,
    StGenRdI,
    StGenRdJ,
    StGenWrJ,
    StGenWrI,
    StOut
  } rc4_state_e;

endpackage

// File: rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// RC4 stream cipher top level: sequencer around one 256 x 8 permutation memory.
// Depends on rtl/rc4_pkg.sv.
//
// Each accepted beat goes through four states of read, swap and write-back on the
// permutation memory (StGenRdI, StGenRdJ, StGenWrJ, StGenWrI), then StOut, which
// uses the keystream lookup and waits while the output register is full. The memory
// has a single write port, so the two halves of each swap are written in separate
// states. The first beat of every message is preceded by a key schedule: StFill
// fills the table with the identity, then four states per entry do the 256 key
// steps. A new beat is taken while a finished result still waits on the output.
module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KeyMaxBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rc4_pkg::KeyRegW-1:0]   cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rc4_pkg::ByteW-1:0]     data_byte_i,
  input  logic                          last_of_message_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rc4_pkg::ByteW-1:0]     out_byte_o,
  output logic                          out_last_o
);
  import rc4_pkg::*;

  localparam int unsigned TableDepth = 2 ** TableAw;
  localparam logic [TableAw-1:0] LastEntry = TableAw'(TableDepth - 1);
  localparam logic [KeyIdxW-1:0] LastKeyIdx = KeyIdxW'(KEY_BYTES - 1);

  rc4_state_e state_q, state_d;

  logic [KeyRegW-1:0]  key_lo_q, key_hi_q;
  logic [TableAw-1:0]  cnt_q, cnt_d;
  logic [KeyIdxW-1:0]  kidx_q, kidx_d;
  logic [TableAw-1:0]  i_q, i_d, j_q, j_d;
  logic [ByteW-1:0]    si_q, si_d, sj_q, sj_d;
  logic [ByteW-1:0]    data_q, data_d;
  logic                last_q, last_d;
  logic                need_q, need_d;
  logic                fwd_q, fwd_d;
  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  // Permutation memory signals.
  logic [ByteW-1:0]    perm_mem [TableDepth];
  logic                mem_we, mem_re;
  logic [TableAw-1:0]  mem_waddr, mem_raddr;
  logic [ByteW-1:0]    mem_wdata, mem_rdata_q;

  // Key byte for the current schedule step.
  logic [2*KeyRegW-1:0] key_all;
  logic [ByteW-1:0]     key_byte;
  logic [TableAw-1:0]   j_sched, j_gen, t_addr;
  logic [ByteW-1:0]     keystream;
  logic                 in_accept, out_take;

  assign key_all  = {key_hi_q, key_lo_q};
  assign key_byte = key_all[{kidx_q, 3'b000} +: ByteW];
  assign j_sched  = j_q + mem_rdata_q + key_byte;
  assign j_gen    = j_q + mem_rdata_q;
  assign t_addr   = si_q + sj_q;
  assign keystream = fwd_q ? sj_q : mem_rdata_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= perm_mem[mem_raddr];
    end
  end

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyLow:  key_lo_q <= cfg_wdata_i;
        CfgKeyHigh: key_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      kidx_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      need_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kidx_q      <= kidx_d;
      i_q         <= i_d;
      j_q         <= j_d;
      need_q      <= need_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    data_q     <= data_d;
    last_q     <= last_d;
    fwd_q      <= fwd_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // Sequencer: next state, memory accesses and result loading.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kidx_d      = kidx_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    data_d      = data_q;
    last_d      = last_q;
    need_d      = need_q;
    fwd_d       = fwd_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = cnt_q;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          data_d = data_byte_i;
          last_d = last_of_message_i;
          if (need_q) begin
            cnt_d   = '0;
            state_d = StFill;
          end else begin
            state_d = StGenRdI;
          end
        end
      end

      // Load the identity permutation, one entry per cycle.
      StFill: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastEntry) begin
          kidx_d  = '0;
          j_d     = '0;
          state_d = StKsRdN;
        end
      end

      // Key schedule: fetch S[n].
      StKsRdN: begin
        mem_re  = 1'b1;
        state_d = StKsRdJ;
      end

      // Advance j and fetch S[j].
      StKsRdJ: begin
        si_d      = mem_rdata_q;
        j_d       = j_sched;
        mem_re    = 1'b1;
        mem_raddr = j_sched;
        state_d   = StKsWrJ;
      end

      // First half of the swap: S[j] takes the old S[n].
      StKsWrJ: begin
        sj_d      = mem_rdata_q;
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        state_d   = StKsWrN;
      end

      // Second half of the swap, then move on to the next entry.
      StKsWrN: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = sj_q;
        cnt_d     = cnt_q + 1'b1;
        kidx_d    = (kidx_q == LastKeyIdx) ? '0 : kidx_q + 1'b1;
        if (cnt_q == LastEntry) begin
          i_d     = '0;
          j_d     = '0;
          need_d  = 1'b0;
          state_d = StGenRdI;
        end else begin
          state_d = StKsRdN;
        end
      end

      // Keystream step: advance i and fetch S[i].
      StGenRdI: begin
        i_d       = i_q + 1'b1;
        mem_re    = 1'b1;
        mem_raddr = i_q + 1'b1;
        state_d   = StGenRdJ;
      end

      // Advance j and fetch S[j].
      StGenRdJ: begin
        si_d      = mem_rdata_q;
        j_d       = j_gen;
        mem_re    = 1'b1;
        mem_raddr = j_gen;
        state_d   = StGenWrJ;
      end

      // S[j] takes the old S[i].
      StGenWrJ: begin
        sj_d      = mem_rdata_q;
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        state_d   = StGenWrI;
      end

      // S[i] takes the old S[j]; fetch S[t] in the same cycle. When t equals i
      // the entry is being written now, so its new value is forwarded.
      StGenWrI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = sj_q;
        mem_re    = 1'b1;
        mem_raddr = t_addr;
        fwd_d     = (t_addr == i_q);
        state_d   = StOut;
      end

      // Hand the result to the output register once it is free.
      StOut: begin
        if (!out_valid_q || out_take) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ keystream;
          out_last_d  = last_q;
          if (last_q) begin
            need_d = 1'b1;
          end
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rc4_stream_cipher: directed table, then random messages and keys.
// Depends on rtl/rc4_pkg.sv and rtl/rc4_stream_cipher.sv.
module tb;
  import rc4_pkg::*;

  localparam int unsigned TableSize   = 1 << TableAw;
  localparam int unsigned KeyBytes    = KeyMaxBytes;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned CycleLimit  = 8_000_000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumDirected = 18;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [KeyRegW-1:0] key_word_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } cipher_beat_t;

  typedef struct {
    byte_t     data;
    logic      last;
    logic      rekey;
    key_word_t key_lo;
    key_word_t key_hi;
  } directed_row_t;

  // Directed stimulus: field extremes, single-byte messages, a key change in the
  // middle of a message, and keys at their extremes.
  directed_row_t directed [NumDirected] = '{
    '{8'h00, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'hFF, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h5A, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'hFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{8'h00, 1'b0, 1'b1, 64'h0807_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09},
    '{8'h00, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h80, 1'b0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
    '{8'h01, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'h7F, 1'b0, 1'b1, 64'h0, 64'h0},
    '{8'hFE, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 64'h0},
    '{8'hFF, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h33, 1'b1, 1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF},
    '{8'hC3, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
    '{8'h3C, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  // Block ports.
  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i        = CfgKeyLow;
  key_word_t         cfg_wdata_i       = '0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  byte_t             data_byte_i       = '0;
  logic              last_of_message_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  byte_t             out_byte_o;
  logic              out_last_o;

  // Predictor state.
  byte_t     sbox [TableSize];
  byte_t     gen_i;
  byte_t     gen_j;
  logic      schedule_due;
  key_word_t key_lo_q;
  key_word_t key_hi_q;

  cipher_beat_t pending_cipher_q [$];

  int unsigned cycle_cnt    = 0;
  int unsigned sent_cnt     = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned msg_cnt      = 0;
  int unsigned msg_len      = 0;
  int unsigned longest_msg  = 0;
  int unsigned key_loads    = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_left   = 0;
  int unsigned stall_hold   = 0;
  int unsigned stall_mode   = 0;

  rc4_stream_cipher dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run the key schedule when a message starts, then one generation step.
  function automatic cipher_beat_t encrypt_byte(byte_t data, logic last);
    byte_t        j;
    byte_t        t;
    byte_t        tmp;
    byte_t        kb;
    int unsigned  k;
    cipher_beat_t res;
    if (schedule_due) begin
      for (int n = 0; n < TableSize; n++) sbox[n] = byte_t'(n);
      j = '0;
      for (int n = 0; n < TableSize; n++) begin
        k  = n % KeyBytes;
        kb = (k < 8) ? key_lo_q[8*(k%8) +: 8] : key_hi_q[8*(k%8) +: 8];
        j  = j + sbox[n] + kb;
        tmp     = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = tmp;
      end
      gen_i        = '0;
      gen_j        = '0;
      schedule_due = 1'b0;
    end
    gen_i       = gen_i + 8'd1;
    gen_j       = gen_j + sbox[gen_i];
    tmp         = sbox[gen_i];
    sbox[gen_i] = sbox[gen_j];
    sbox[gen_j] = tmp;
    t           = sbox[gen_i] + sbox[gen_j];
    res.data    = data ^ sbox[t];
    res.last    = last;
    if (last) schedule_due = 1'b1;
    return res;
  endfunction

  // Track key writes, check each result beat against the oldest prediction, and
  // predict every accepted input beat.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    cipher_beat_t got;
    cipher_beat_t want;
    if (!rst_ni) begin
      schedule_due = 1'b1;
      gen_i        = '0;
      gen_j        = '0;
      key_lo_q     = '0;
      key_hi_q     = '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgKeyLow) key_lo_q = cfg_wdata_i;
        else if (cfg_idx_i == CfgKeyHigh) key_hi_q = cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i) begin
        checked_cnt++;
        got.data = out_byte_o;
        got.last = out_last_o;
        if (pending_cipher_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("[%0t] unexpected result beat: byte %02h last %0b", $realtime,
                     got.data, got.last);
        end else begin
          want = pending_cipher_q.pop_front();
          if (got.data !== want.data || got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
              $display("[%0t] result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       $realtime, checked_cnt, want.data, want.last, got.data, got.last);
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_cipher_q.push_back(encrypt_byte(data_byte_i, last_of_message_i));
    end
  end

  // Receiver stall pattern: free-running, random, or long holds, switching modes.
  always @(posedge clk_i) begin
    if (cycle_cnt % 256 == 0) stall_mode <= $urandom_range(0, 2);
    if (stall_hold > 0) begin
      stall_hold  <= stall_hold - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            out_stall_i <= 1'b1;
            stall_hold  <= $urandom_range(1, 12);
          end else begin
            out_stall_i <= 1'b0;
          end
        end
      endcase
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cycle_cnt,
               checked_cnt, sent_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted; then maybe open a gap.
  task automatic send_beat(byte_t data, logic last);
    int unsigned gap;
    data_byte_i       <= data;
    last_of_message_i <= last;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_cnt++;
    msg_len++;
    if (msg_len > longest_msg) longest_msg = msg_len;
    if (last) begin
      msg_cnt++;
      msg_len = 0;
    end
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(20, 80);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = (quiet_left > 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every result is back and the block has settled.
  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (checked_cnt < sent_cnt) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_key(key_word_t lo, key_word_t hi);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgKeyLow;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CfgKeyHigh;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_loads++;
  endtask

  function automatic key_word_t pick_key_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int unsigned len;
    int unsigned cut;
    int unsigned sel;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < NumDirected; r++) begin
      if (directed[r].rekey) load_key(directed[r].key_lo, directed[r].key_hi);
      send_beat(directed[r].data, directed[r].last);
    end

    // Random messages: mostly short, some long enough to wrap the indices.
    while (sent_cnt < NumDirected + RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 10)      len = 1;
      else if (sel < 80) len = $urandom_range(2, 24);
      else if (sel < 95) len = $urandom_range(25, 80);
      else               len = $urandom_range(257, 300);
      if ($urandom_range(0, 3) == 0) load_key(pick_key_word(), pick_key_word());
      cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int b = 0; b < len; b++) begin
        // Occasionally stop mid-message, with or without a new key.
        if (cut != 0 && b == cut) begin
          if ($urandom_range(0, 1) == 0) load_key(pick_key_word(), pick_key_word());
          else wait_idle();
        end
        send_beat(byte_t'($urandom_range(0, 255)), b == len - 1);
      end
    end

    wait_idle();
    if (pending_cipher_q.size() != 0) begin
      mismatch_cnt++;
      $display("%0d predicted results never arrived", pending_cipher_q.size());
    end
    $display("Ran %0d bytes in %0d messages (longest %0d bytes) over %0d key loads.",
             sent_cnt, msg_cnt, longest_msg, key_loads);
    $display("Checked %0d result beats in %0d cycles, %0d mismatches.", checked_cnt,
             cycle_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
